>>> design/rsl_pkg.sv
// shared types and constants for the reassembly slot table
// no dependencies

package rsl_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int IDENT_W     = 16;
  localparam int STAMP_W     = 32;
  localparam int SLOT_W      = 4;
  localparam int STATUS_W    = 3;

  localparam logic [STATUS_W-1:0] ST_MATCH   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FREE    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EVICT   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RELEASE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISS    = 3'd4;

  localparam logic MODE_CLAIM   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  typedef struct packed {
    logic start;
    logic issue;
    logic commit;
  } rsl_cmd_t;

  typedef struct packed {
    logic issue_last;
    logic out_free;
  } rsl_sts_t;

endpackage

>>> design/rsl_ram.sv
// generic single write port ram with registered read
// no dependencies

module rsl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/rsl_ctrl.sv
// controller state machine: accept, scan, drain, commit
// depends on rsl_pkg

module rsl_ctrl
  import rsl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  rsl_sts_t sts,
  output rsl_cmd_t cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd.start  = 1'b0;
    cmd.issue  = 1'b0;
    cmd.commit = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.issue = 1'b1;
        if (sts.issue_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

>>> design/rsl_dpath.sv
// datapath: request latch, entry scan, valid bits, entry ram, result register
// depends on rsl_pkg and rsl_ram

module rsl_dpath
  import rsl_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rsl_cmd_t            cmd,
  output rsl_sts_t            sts,
  input  logic                in_mode,
  input  logic [IDENT_W-1:0]  in_frag_id,
  input  logic [STAMP_W-1:0]  in_now_time,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SLOT_W-1:0]   out_slot,
  output logic [STATUS_W-1:0] out_status
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int ENT_W = IDENT_W + STAMP_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  logic                mode_r;
  logic [IDENT_W-1:0]  frag_r;
  logic [STAMP_W-1:0]  now_r;
  logic [IDX_W-1:0]    addr_r;
  logic [IDX_W-1:0]    idx_d_r;
  logic                cmp_en_r;
  logic                hit_found_r;
  logic [IDX_W-1:0]    hit_idx_r;
  logic                free_found_r;
  logic [IDX_W-1:0]    free_idx_r;
  logic [STAMP_W-1:0]  min_stamp_r;
  logic [IDX_W-1:0]    min_idx_r;
  logic [ENTRIES-1:0]  valid_r;
  logic [ENTRIES-1:0]  valid_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [STATUS_W-1:0] out_status_r;

  logic [ENT_W-1:0]    rdata;
  logic [IDENT_W-1:0]  cur_ident;
  logic [STAMP_W-1:0]  cur_stamp;
  logic                cur_valid;
  logic                wr_en;
  logic [IDX_W-1:0]    pick;
  logic [IDX_W+SLOT_W-1:0] pick_ext;
  logic [STATUS_W-1:0] status_nxt;

  rsl_ram #(
    .WIDTH (ENT_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (pick),
    .wdata ({frag_r, now_r}),
    .re    (cmd.issue),
    .raddr (addr_r),
    .rdata (rdata)
  );

  assign cur_ident = rdata[ENT_W-1:STAMP_W];
  assign cur_stamp = rdata[STAMP_W-1:0];
  assign cur_valid = valid_r[idx_d_r];

  // request latch and read address
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mode_r <= in_mode;
      frag_r <= in_frag_id;
      now_r  <= in_now_time;
      addr_r <= '0;
    end else if (cmd.issue) begin
      addr_r <= addr_r + 1'b1;
    end
    idx_d_r <= addr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_en_r <= 1'b0;
    end else begin
      cmp_en_r <= cmd.issue;
    end
  end

  // scan accumulators
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end else if (cmp_en_r) begin
      if (cur_valid && (cur_ident == frag_r) && !hit_found_r) begin
        hit_found_r <= 1'b1;
        hit_idx_r   <= idx_d_r;
      end
      if (!cur_valid) begin
        free_found_r <= 1'b1;
        free_idx_r   <= idx_d_r;
      end
      // ties go to the higher index
      if ((idx_d_r == '0) || (cur_stamp <= min_stamp_r)) begin
        min_stamp_r <= cur_stamp;
        min_idx_r   <= idx_d_r;
      end
    end
  end

  // commit decision
  always_comb begin
    wr_en      = 1'b0;
    pick       = '0;
    status_nxt = ST_MATCH;
    valid_nxt  = valid_r;
    if (mode_r == MODE_RELEASE) begin
      if (hit_found_r) begin
        pick       = hit_idx_r;
        status_nxt = ST_RELEASE;
        if (cmd.commit) begin
          valid_nxt[hit_idx_r] = 1'b0;
        end
      end else begin
        status_nxt = ST_MISS;
      end
    end else if (hit_found_r) begin
      pick       = hit_idx_r;
      status_nxt = ST_MATCH;
    end else begin
      if (free_found_r) begin
        pick       = free_idx_r;
        status_nxt = ST_FREE;
      end else begin
        pick       = min_idx_r;
        status_nxt = ST_EVICT;
      end
      wr_en = cmd.commit;
      if (cmd.commit) begin
        valid_nxt[pick] = 1'b1;
      end
    end
  end

  assign pick_ext = {{SLOT_W{1'b0}}, pick};

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_slot_r   <= pick_ext[SLOT_W-1:0];
      out_status_r <= status_nxt;
    end
  end

  assign sts.issue_last = (addr_r == LAST_IDX);
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign out_valid  = out_valid_r;
  assign out_slot   = out_slot_r;
  assign out_status = out_status_r;

endmodule

>>> design/reassembly_slot_table_top.sv
// reassembly slot table top level: controller plus datapath
// result: registered at commit, after the entry scan, the drain state and a final state that
// waits for the result register to be free; a new transaction is accepted only after the commit,
// and the scan of the entry ram reads one entry per cycle
// reset: synchronous active-low rst_n frees every entry; ram contents are not cleared
// depends on rsl_pkg, rsl_ctrl, rsl_dpath, rsl_ram

module reassembly_slot_table_top
  import rsl_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_mode,
  input  logic [IDENT_W-1:0]  in_frag_id,
  input  logic [STAMP_W-1:0]  in_now_time,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SLOT_W-1:0]   out_slot,
  output logic [STATUS_W-1:0] out_status
);

  rsl_cmd_t cmd;
  rsl_sts_t sts;

  rsl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rsl_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_mode     (in_mode),
    .in_frag_id  (in_frag_id),
    .in_now_time (in_now_time),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_slot    (out_slot),
    .out_status  (out_status)
  );

  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a transaction is in flight");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("commit did not load the result register");

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> sts.out_free)
    else $error("result register overwritten while stalled");

  a_miss_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_MISS)) |-> (out_slot == '0))
    else $error("release miss with nonzero slot");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ST_MISS))
    else $error("undefined status code");

endmodule
